/* sv/ble_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants for the bully leader election node.
// No dependencies; every other file imports this package.
package ble_pkg;

  localparam int unsigned MAX_NODES_DEF = 16;
  localparam int unsigned ID_W          = 5;
  localparam int unsigned TICK_W        = 16;
  localparam int unsigned THR_W         = 24;
  localparam int unsigned RESULT_SLOTS  = 16;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned PADDR_W       = 4;
  localparam int unsigned PDATA_W       = 32;

  localparam logic [ID_W-1:0]   NODE_ID_RST  = 5'd1;
  localparam logic [ID_W-1:0]   NODE_CNT_RST = 5'd16;
  localparam logic [TICK_W-1:0] SCALE_RST    = 16'd10;

  // opcodes
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_MSG     = 3'd1;
  localparam logic [2:0] OP_DISABLE = 3'd2;
  localparam logic [2:0] OP_ENABLE  = 3'd3;
  localparam logic [2:0] OP_FORCE   = 3'd4;

  // message kinds
  localparam logic [2:0] KIND_ELECTION = 3'd1;
  localparam logic [2:0] KIND_OK       = 3'd2;
  localparam logic [2:0] KIND_LEADER   = 3'd3;
  localparam logic [2:0] KIND_ALIVE    = 3'd4;
  localparam logic [2:0] KIND_ALIVE_OK = 3'd5;

  // register word indexes
  localparam logic [1:0] REG_NODE_ID    = 2'd0;
  localparam logic [1:0] REG_NODE_COUNT = 2'd1;
  localparam logic [1:0] REG_SCALE      = 2'd2;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [2:0]      msg_kind;
    logic [ID_W-1:0] sender_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0]      send_kind;
    logic [ID_W-1:0] dest_id;
    logic            last;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0]         node_id;
    logic [ID_W-1:0]         eff_count;
    logic signed [THR_W-1:0] thr;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic step;
  } walk_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_t;

endpackage

/* sv/ble_regs.sv */
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port, plus the registered
// timeout threshold product. Depends on ble_pkg.
module ble_regs
  import ble_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output cfg_t               cfg
);

  localparam int unsigned CAP = (MAX_NODES > 31) ? 31 : MAX_NODES;
  localparam logic [ID_W-1:0] CAP_ID = ID_W'(CAP);

  logic [ID_W-1:0]         node_id_r, node_id_nxt;
  logic [ID_W-1:0]         node_cnt_r, node_cnt_nxt;
  logic [TICK_W-1:0]       scale_r, scale_nxt;
  logic signed [THR_W-1:0] thr_r, thr_nxt;
  logic [ID_W-1:0]         eff;
  logic signed [ID_W+1:0]  diff;
  logic                    wr_en;

  assign wr_en = psel & penable & pwrite;
  assign eff   = (node_cnt_r > CAP_ID) ? CAP_ID : node_cnt_r;
  assign diff  = $signed({2'b00, eff}) - $signed({2'b00, node_id_r});

  always_comb begin
    node_id_nxt  = node_id_r;
    node_cnt_nxt = node_cnt_r;
    scale_nxt    = scale_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_NODE_ID:    node_id_nxt  = pwdata[ID_W-1:0];
        REG_NODE_COUNT: node_cnt_nxt = pwdata[ID_W-1:0];
        REG_SCALE:      scale_nxt    = pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
    thr_nxt = THR_W'(diff * $signed({1'b0, scale_r}));
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NODE_ID:    prdata = PDATA_W'(node_id_r);
      REG_NODE_COUNT: prdata = PDATA_W'(node_cnt_r);
      REG_SCALE:      prdata = PDATA_W'(scale_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r  <= NODE_ID_RST;
      node_cnt_r <= NODE_CNT_RST;
      scale_r    <= SCALE_RST;
    end else begin
      node_id_r  <= node_id_nxt;
      node_cnt_r <= node_cnt_nxt;
      scale_r    <= scale_nxt;
    end
  end

  always_ff @(posedge clk) begin
    thr_r <= thr_nxt;
  end

  assign cfg.node_id   = node_id_r;
  assign cfg.eff_count = eff;
  assign cfg.thr       = thr_r;

endmodule

/* sv/ble_walk.sv */
`timescale 1ns / 1ps
// Broadcast destination walker: one incrementer and compare, stepped once
// per emitted broadcast word, skipping this node's own id. Depends on ble_pkg.
module ble_walk
  import ble_pkg::*;
(
  input  logic            clk,
  input  walk_ctl_t       ctl,
  input  logic [ID_W-1:0] node_id,
  output logic [ID_W-1:0] dest
);

  logic [ID_W-1:0] cur_r, cur_nxt;
  logic [ID_W-1:0] inc1;

  assign inc1 = cur_r + ID_W'(1);

  always_comb begin
    cur_nxt = cur_r;
    if (ctl.start) begin
      cur_nxt = (node_id == ID_W'(1)) ? ID_W'(2) : ID_W'(1);
    end else if (ctl.step) begin
      cur_nxt = (inc1 == node_id) ? inc1 + ID_W'(1) : inc1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  assign dest = cur_r;

endmodule

/* sv/ble_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer: decodes one event, updates the election state and emits the
// resulting words through the output register. Depends on ble_pkg.
module ble_ctrl
  import ble_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg,
  input  logic            in_valid,
  input  in_word_t        in_data,
  output logic            in_ready,
  output logic            out_valid,
  output out_word_t       out_data,
  input  logic            out_ready,
  output walk_ctl_t       walk_ctl,
  input  logic [ID_W-1:0] walk_dest
);

  state_t            state_r, state_nxt;
  in_word_t          item_r, item_nxt;
  logic [ID_W-1:0]   leader_r, leader_nxt;
  logic              run_r, run_nxt;
  logic [TICK_W-1:0] elapsed_r, elapsed_nxt;
  logic              dis_r, dis_nxt;
  logic              single_r, single_nxt;
  logic [2:0]        skind_r, skind_nxt;
  logic [ID_W-1:0]   sdest_r, sdest_nxt;
  logic [2:0]        bkind_r, bkind_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              oval_r, oval_nxt;
  out_word_t         oword_r, oword_nxt;

  logic [TICK_W-1:0] el_inc;
  logic              expired;
  logic              bcast;
  logic              self_in;
  logic [ID_W-1:0]   bcnt;
  logic [CNT_W:0]    sum;
  logic              load;
  logic              is_last;

  assign el_inc  = (run_r && elapsed_r != '1) ? elapsed_r + TICK_W'(1) : elapsed_r;
  assign expired = run_r && ($signed({{(THR_W-TICK_W){1'b0}}, el_inc}) > cfg.thr);
  assign self_in = (cfg.node_id != '0) && (cfg.node_id <= cfg.eff_count);
  assign load    = !oval_r || out_ready;
  assign is_last = (k_r == total_r - CNT_W'(1));

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    leader_nxt  = leader_r;
    run_nxt     = run_r;
    elapsed_nxt = elapsed_r;
    dis_nxt     = dis_r;
    single_nxt  = single_r;
    skind_nxt   = skind_r;
    sdest_nxt   = sdest_r;
    bkind_nxt   = bkind_r;
    total_nxt   = total_r;
    k_nxt       = k_r;
    oval_nxt    = oval_r && !out_ready;
    oword_nxt   = oword_r;
    walk_ctl    = '0;
    bcast       = 1'b0;
    bcnt        = '0;
    sum         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        single_nxt = 1'b0;
        bkind_nxt  = KIND_ELECTION;
        case (item_r.opcode)
          OP_TICK: begin
            elapsed_nxt = el_inc;
            if (leader_r == '0 && !run_r) begin
              bcast       = 1'b1;
              run_nxt     = 1'b1;
              elapsed_nxt = '0;
            end else if (leader_r == '0 && expired) begin
              bcast       = 1'b1;
              bkind_nxt   = KIND_LEADER;
              leader_nxt  = cfg.node_id;
              run_nxt     = 1'b0;
              elapsed_nxt = '0;
            end else if (leader_r != '0 && !dis_r) begin
              if (!run_r && leader_r != cfg.node_id) begin
                single_nxt  = 1'b1;
                skind_nxt   = KIND_ALIVE;
                sdest_nxt   = leader_r;
                run_nxt     = 1'b1;
                elapsed_nxt = '0;
              end else if (expired) begin
                bcast       = 1'b1;
                leader_nxt  = '0;
                run_nxt     = 1'b1;
                elapsed_nxt = '0;
              end
            end
          end
          OP_MSG: begin
            if (item_r.msg_kind == KIND_LEADER) begin
              leader_nxt  = item_r.sender_id;
              run_nxt     = 1'b0;
              elapsed_nxt = '0;
            end
            if (!dis_r) begin
              case (item_r.msg_kind)
                KIND_ELECTION: begin
                  if (item_r.sender_id < cfg.node_id) begin
                    single_nxt = 1'b1;
                    skind_nxt  = KIND_OK;
                    sdest_nxt  = item_r.sender_id;
                    bcast      = 1'b1;
                    leader_nxt = '0;
                  end
                  run_nxt     = 1'b1;
                  elapsed_nxt = '0;
                end
                KIND_OK: begin
                  run_nxt     = 1'b1;
                  elapsed_nxt = '0;
                end
                KIND_ALIVE: begin
                  if (leader_r != '0 && leader_r == cfg.node_id) begin
                    single_nxt = 1'b1;
                    skind_nxt  = KIND_ALIVE_OK;
                    sdest_nxt  = item_r.sender_id;
                  end
                end
                KIND_ALIVE_OK: begin
                  run_nxt     = 1'b0;
                  elapsed_nxt = '0;
                end
                default: ;
              endcase
            end
          end
          OP_DISABLE: dis_nxt = 1'b1;
          OP_ENABLE:  dis_nxt = 1'b0;
          OP_FORCE: begin
            if (!dis_r) begin
              single_nxt  = 1'b1;
              skind_nxt   = KIND_ALIVE;
              sdest_nxt   = leader_r;
              run_nxt     = 1'b1;
              elapsed_nxt = '0;
            end
          end
          default: ;
        endcase

        // word count: optional direct word, then the broadcast, capped
        if (bcast) begin
          bcnt = cfg.eff_count - ID_W'(self_in);
        end
        sum = {1'b0, bcnt} + (CNT_W+1)'(single_nxt);
        total_nxt = (sum > (CNT_W+1)'(RESULT_SLOTS)) ? CNT_W'(RESULT_SLOTS) : sum[CNT_W-1:0];
        k_nxt          = '0;
        walk_ctl.start = 1'b1;
        state_nxt      = (total_nxt == '0) ? ST_IDLE : ST_EMIT;
      end

      ST_EMIT: begin
        if (load) begin
          oval_nxt       = 1'b1;
          oword_nxt.last = is_last;
          if (k_r == '0 && single_r) begin
            oword_nxt.send_kind = skind_r;
            oword_nxt.dest_id   = sdest_r;
          end else begin
            oword_nxt.send_kind = bkind_r;
            oword_nxt.dest_id   = walk_dest;
            walk_ctl.step       = 1'b1;
          end
          k_nxt = k_r + CNT_W'(1);
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      leader_r  <= '0;
      run_r     <= 1'b0;
      elapsed_r <= '0;
      dis_r     <= 1'b0;
      oval_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      leader_r  <= leader_nxt;
      run_r     <= run_nxt;
      elapsed_r <= elapsed_nxt;
      dis_r     <= dis_nxt;
      oval_r    <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    single_r <= single_nxt;
    skind_r  <= skind_nxt;
    sdest_r  <= sdest_nxt;
    bkind_r  <= bkind_nxt;
    total_r  <= total_nxt;
    k_r      <= k_nxt;
    oword_r  <= oword_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = oval_r;
  assign out_data  = oword_r;

endmodule

/* sv/bully_leader_election_node.sv */
`timescale 1ns / 1ps
// Bully leader election node, top level. Depends on ble_pkg, ble_regs,
// ble_walk and ble_ctrl.
// Flow: an accepted event is decoded in EXEC, then in EMIT its words enter the
// output register one per cycle while out_ready allows, the single broadcast
// walker emitting one destination a cycle. Input waits for the last word.
// Reset: synchronous, active low; clears leader, timer and disable flag and
// loads the registers with node_id 1, node_count 16, timeout_scale 10.
module bully_leader_election_node
  import ble_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t            cfg;
  walk_ctl_t       walk_ctl;
  logic [ID_W-1:0] walk_dest;

  assign pready = 1'b1;

  ble_regs #(
    .MAX_NODES(MAX_NODES)
  ) u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg    (cfg)
  );

  ble_walk u_walk (
    .clk    (clk),
    .ctl    (walk_ctl),
    .node_id(cfg.node_id),
    .dest   (walk_dest)
  );

  ble_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_ready(out_ready),
    .walk_ctl (walk_ctl),
    .walk_dest(walk_dest)
  );

endmodule

/* sim/bully_leader_election_node_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for bully_leader_election_node: directed and random event
// words, APB register settings, field-by-field check of every message word.
// Depends on ble_pkg and the bully_leader_election_node RTL.
module bully_leader_election_node_test;
  import ble_pkg::*;

  localparam int QUIET_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int LONG_TICKS     = 20;
  localparam int MAX_REPORTS    = 100;

  // Election node shadow: predicts the message words of each accepted event.
  class election_scoreboard;
    logic [ID_W-1:0]   self_id;
    logic [ID_W-1:0]   peer_count;
    logic [TICK_W-1:0] tick_scale;
    logic [ID_W-1:0]   leader;
    logic              timing;
    logic [TICK_W-1:0] ticks;
    logic              disabled_flag;
    out_word_t         pending_msgs[$];
    out_word_t         event_msgs[$];
    int                errors;
    int                events_seen;
    int                words_seen;

    function new();
      self_id       = NODE_ID_RST;
      peer_count    = NODE_CNT_RST;
      tick_scale    = SCALE_RST;
      leader        = '0;
      timing        = 1'b0;
      ticks         = '0;
      disabled_flag = 1'b0;
      errors        = 0;
      events_seen   = 0;
      words_seen    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_NODE_ID:    self_id = val[ID_W-1:0];
        REG_NODE_COUNT: peer_count = val[ID_W-1:0];
        REG_SCALE:      tick_scale = val[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    function int span();
      return (peer_count > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(peer_count);
    endfunction

    function bit timer_expired();
      int thr;
      thr = (span() - int'(self_id)) * int'(tick_scale);
      return timing && (int'(ticks) > thr);
    endfunction

    function void start_timer();
      timing = 1'b1;
      ticks  = '0;
    endfunction

    function void stop_timer();
      timing = 1'b0;
      ticks  = '0;
    endfunction

    // Drop anything past the result slots of one event.
    function void add_msg(logic [2:0] kind, logic [ID_W-1:0] dest);
      out_word_t m;
      if (event_msgs.size() >= RESULT_SLOTS) return;
      m.send_kind = kind;
      m.dest_id   = dest;
      m.last      = 1'b0;
      event_msgs.push_back(m);
    endfunction

    function void broadcast(logic [2:0] kind);
      for (int i = 1; i <= span(); i++)
        if (i != int'(self_id)) add_msg(kind, i[ID_W-1:0]);
    endfunction

    function void note_event(in_word_t w);
      out_word_t m;
      event_msgs.delete();
      events_seen++;
      case (w.opcode)
        OP_TICK: begin
          if (timing && ticks != '1) ticks++;
          if (leader == 0 && !timing) begin
            broadcast(KIND_ELECTION);
            start_timer();
          end else if (leader == 0 && timer_expired()) begin
            broadcast(KIND_LEADER);
            leader = self_id;
            stop_timer();
          end else if (leader != 0 && !disabled_flag) begin
            if (!timing && leader != self_id) begin
              add_msg(KIND_ALIVE, leader);
              start_timer();
            end else if (timer_expired()) begin
              broadcast(KIND_ELECTION);
              leader = '0;
              start_timer();
            end
          end
        end
        OP_MSG: begin
          // a leader announcement lands even while disabled
          if (w.msg_kind == KIND_LEADER) begin
            leader = w.sender_id;
            stop_timer();
          end
          if (!disabled_flag) begin
            case (w.msg_kind)
              KIND_ELECTION: begin
                if (w.sender_id < self_id) begin
                  add_msg(KIND_OK, w.sender_id);
                  broadcast(KIND_ELECTION);
                  leader = '0;
                end
                start_timer();
              end
              KIND_OK:       start_timer();
              KIND_ALIVE: begin
                if (leader != 0 && leader == self_id) add_msg(KIND_ALIVE_OK, w.sender_id);
              end
              KIND_ALIVE_OK: stop_timer();
              default: ;
            endcase
          end
        end
        OP_DISABLE: disabled_flag = 1'b1;
        OP_ENABLE:  disabled_flag = 1'b0;
        OP_FORCE: begin
          if (!disabled_flag) begin
            add_msg(KIND_ALIVE, leader);
            start_timer();
          end
        end
        default: ;
      endcase
      if (event_msgs.size() > 0) begin
        m = event_msgs.pop_back();
        m.last = 1'b1;
        event_msgs.push_back(m);
      end
      foreach (event_msgs[k]) pending_msgs.push_back(event_msgs[k]);
    endfunction

    function void report_field(string name, int want, int got);
      errors++;
      if (errors <= MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (pending_msgs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("unexpected word: send_kind %0d dest_id %0d last %0d",
                 got.send_kind, got.dest_id, got.last);
        return;
      end
      want = pending_msgs.pop_front();
      words_seen++;
      if (got.send_kind !== want.send_kind) report_field("send_kind", want.send_kind, got.send_kind);
      if (got.dest_id !== want.dest_id) report_field("dest_id", want.dest_id, got.dest_id);
      if (got.last !== want.last) report_field("last", want.last, got.last);
    endfunction
  endclass

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_word_t           in_data  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_data;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  election_scoreboard sb = new();

  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int holdoff_asked  = 0;
  int holdoff_done   = 0;
  int quiet_cycles   = 0;
  int settings_used  = 0;

  bully_leader_election_node dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_event(in_data);
      if (out_valid && out_ready) sb.check_word(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[bully_leader_election_node] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (holdoff_done != holdoff_asked) begin
        for (int k = 0; k < HOLDOFF_CYCLES; k++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
        holdoff_done++;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic in_word_t make_event(logic [2:0] op, logic [2:0] kind,
                                          logic [ID_W-1:0] sender);
    in_word_t w;
    w.opcode    = op;
    w.msg_kind  = kind;
    w.sender_id = sender;
    return w;
  endfunction

  // Mostly well-formed protocol traffic, some raw noise.
  function automatic in_word_t random_event();
    in_word_t    w;
    int unsigned pick;
    pick = $urandom_range(99);
    w = make_event(OP_TICK, 3'($urandom_range(7)), 5'($urandom_range(31)));
    if (pick < 40) begin
      w.opcode = OP_TICK;
    end else if (pick < 75) begin
      w.opcode    = OP_MSG;
      w.msg_kind  = 3'($urandom_range(KIND_ALIVE_OK, KIND_ELECTION));
      w.sender_id = 5'($urandom_range(int'(sb.peer_count) + 1));
    end else if (pick < 82) begin
      w.opcode = OP_FORCE;
    end else if (pick < 86) begin
      w.opcode = OP_DISABLE;
    end else if (pick < 92) begin
      w.opcode = OP_ENABLE;
    end else begin
      w.opcode = 3'($urandom_range(7));
    end
    return w;
  endfunction

  // Hold valid high from here until the word is taken.
  task automatic offer_event(input in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send(input logic [2:0] op, input logic [2:0] kind,
                      input logic [ID_W-1:0] sender);
    offer_event(make_event(op, kind, sender));
  endtask

  // Drop valid, wait out every expected word, then the block's latency.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apb_check(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      sb.errors++;
      $error("register %0d: expected %0h, got %0h", idx, want, got);
    end
    @(posedge clk);
  endtask

  task automatic configure(input int nid, input int cnt, input int scale);
    apb_write(REG_NODE_ID, nid);
    apb_write(REG_NODE_COUNT, cnt);
    apb_write(REG_SCALE, scale);
    apb_check(REG_NODE_ID, nid);
    apb_check(REG_NODE_COUNT, cnt);
    apb_check(REG_SCALE, scale);
    settings_used++;
  endtask

  task automatic run_random(input int count, input bit pause_midway, input bit hold_rx);
    if (hold_rx) holdoff_asked++;
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) settle();
      offer_event(random_event());
    end
    settle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_check(REG_NODE_ID, NODE_ID_RST);
    apb_check(REG_NODE_COUNT, NODE_CNT_RST);
    apb_check(REG_SCALE, SCALE_RST);
    send(OP_TICK, 3'd0, 5'd0);
    settle();

    // Directed: full election cycle on a five-node ring, then the edge cases.
    configure(3, 5, 1);
    send(OP_MSG, KIND_LEADER, 5'd0);
    send(OP_TICK, 3'd0, 5'd0);
    repeat (3) send(OP_TICK, 3'd0, 5'd0);
    send(OP_MSG, KIND_ALIVE, 5'd5);
    send(OP_MSG, KIND_ELECTION, 5'd1);
    send(OP_MSG, KIND_ELECTION, 5'd4);
    send(OP_MSG, KIND_OK, 5'd5);
    send(OP_MSG, KIND_LEADER, 5'd5);
    send(OP_TICK, 3'd0, 5'd0);
    send(OP_MSG, KIND_ALIVE_OK, 5'd5);
    send(OP_FORCE, 3'd0, 5'd0);
    send(OP_DISABLE, 3'd0, 5'd0);
    repeat (3) send(OP_TICK, 3'd0, 5'd0);
    send(OP_MSG, KIND_ELECTION, 5'd1);
    send(OP_FORCE, 3'd0, 5'd0);
    send(OP_MSG, KIND_LEADER, 5'd0);
    send(OP_TICK, 3'd0, 5'd0);
    send(OP_ENABLE, 3'd0, 5'd0);
    send(3'd7, 3'd7, 5'd31);
    send(OP_MSG, 3'd0, 5'd31);
    send(OP_MSG, 3'd6, 5'd0);
    send(3'd5, KIND_ELECTION, 5'd1);
    send(OP_FORCE, 3'd0, 5'd0);
    settle();

    // Identity above the node count: negative threshold, overflowing reply.
    configure(20, 16, 3);
    send(OP_MSG, KIND_LEADER, 5'd0);
    send(OP_TICK, 3'd0, 5'd0);
    send(OP_TICK, 3'd0, 5'd0);
    send(OP_MSG, KIND_ELECTION, 5'd2);
    send(OP_MSG, KIND_ALIVE, 5'd3);
    settle();

    // Count above the node limit, widest scale.
    configure(16, 31, 65535);
    send(OP_MSG, KIND_LEADER, 5'd0);
    send(OP_TICK, 3'd0, 5'd0);
    send(OP_TICK, 3'd0, 5'd0);
    send(OP_MSG, KIND_ALIVE, 5'd4);
    settle();

    // Identity zero and an empty ring.
    configure(0, 16, 7);
    send(OP_MSG, KIND_LEADER, 5'd0);
    send(OP_TICK, 3'd0, 5'd0);
    send(OP_MSG, KIND_ELECTION, 5'd0);
    send(OP_FORCE, 3'd0, 5'd0);
    settle();
    configure(3, 0, 1);
    send(OP_MSG, KIND_LEADER, 5'd0);
    send(OP_TICK, 3'd0, 5'd0);
    send(OP_TICK, 3'd0, 5'd0);
    send(OP_MSG, KIND_ALIVE, 5'd1);
    settle();

    // Threshold of 65535 and one below: a run of ticks stays far from expiry.
    configure(15, 16, 65535);
    send(OP_MSG, KIND_LEADER, 5'd16);
    send(OP_TICK, 3'd0, 5'd0);
    repeat (LONG_TICKS) send(OP_TICK, 3'd0, 5'd0);
    settle();
    configure(15, 16, 65534);
    send(OP_TICK, 3'd0, 5'd0);
    send(OP_TICK, 3'd0, 5'd0);
    settle();

    tx_idle_pct = 35;
    rx_idle_pct = 58;
    configure(1, 2, 1);
    run_random(40, 1'b1, 1'b0);
    configure(16, 16, 1);
    run_random(40, 1'b0, 1'b0);

    tx_idle_pct = 58;
    rx_idle_pct = 35;
    configure(7, 12, 3);
    run_random(40, 1'b0, 1'b0);
    configure(5, 3, 2);
    run_random(40, 1'b0, 1'b0);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(9, 31, 1);
    run_random(40, 1'b0, 1'b1);
    configure(2, 2, 2);
    run_random(40, 1'b0, 1'b0);

    settle();
    $display("covered %0d events and %0d message words over %0d register settings,",
             sb.events_seen, sb.words_seen, settings_used);
    $display("including overflowing broadcasts, large thresholds and a long output stall");
    if (sb.errors == 0) begin
      $display("[bully_leader_election_node] OK");
    end else begin
      $display("[bully_leader_election_node] ERROR");
    end
    $finish;
  end

endmodule
